// ===== rtl/sfid_pkg.sv =====
// sfid_pkg: shared widths, register indexes and result codes
// for the structured grid face index decoder; no dependencies
package sfid_pkg;

	localparam int CNT_W    = 11;
	localparam int IDX_W    = 32;
	localparam int NODE_W   = 30;
	localparam int CORNER_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_DIM_DEF = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_NODES_I = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODES_J = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODES_K = 2'd2;

	typedef enum logic [1:0] {
		DIR_I = 2'd0,
		DIR_J = 2'd1,
		DIR_K = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHAPE = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	localparam logic [CORNER_W-1:0] CORNERS_2 = 3'd2;
	localparam logic [CORNER_W-1:0] CORNERS_4 = 3'd4;

endpackage

// ===== rtl/structured_face_index_decoder_top.sv =====
// structured_face_index_decoder_top: decodes a flat face index of a structured grid
// into corner nodes, owning cell, direction and status
// depends on sfid_pkg and sfid_div
//
// usage:
//   configuration: cfg_we with cfg_index (0 nodes_i, 1 nodes_j, 2 nodes_k) and cfg_data
//   writes a node count at the clock edge; write only while no request is in flight
//   request: face_index is taken at an edge where start is high and busy is low;
//   busy is never raised, so a new request may be issued every cycle
//   result: all result ports are valid for one cycle while done is high; done rises
//   when the request leaves the output stage, and the result is taken while done is high
//   one result per request, in request order
//   latency is set by two 32-bit restoring dividers at 4 quotient bits per stage
//   (8 stages each) plus 4 stages of face counting and 4 stages of index assembly
//   throughput: one request per cycle sustained
//   reset: arst_n clears the pipeline valid bits and sets all node counts to 1
//   the receiver cannot stall: results are presented once and not held
module structured_face_index_decoder_top #(
	parameter int MAX_DIM = sfid_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sfid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfid_pkg::CNT_W-1:0]        cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [sfid_pkg::IDX_W-1:0]        face_index,
	output logic                              done,
	output logic [sfid_pkg::NODE_W-1:0]       node_a,
	output logic [sfid_pkg::NODE_W-1:0]       node_b,
	output logic [sfid_pkg::NODE_W-1:0]       node_c,
	output logic [sfid_pkg::NODE_W-1:0]       node_d,
	output logic [sfid_pkg::CORNER_W-1:0]     corner_count,
	output logic [sfid_pkg::NODE_W-1:0]       cell_index,
	output logic [1:0]                        face_dir,
	output logic [1:0]                        status
);

	import sfid_pkg::*;

	localparam int P2_W = 2 * CNT_W;
	localparam int P3_W = 3 * CNT_W;

	logic [CNT_W-1:0] ni_q, nj_q, nk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ni_q <= CNT_W'(1);
			nj_q <= CNT_W'(1);
			nk_q <= CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODES_I: ni_q <= cfg_data;
				REG_NODES_J: nj_q <= cfg_data;
				REG_NODES_K: nk_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shape decode: user keeps it stable with requests in flight; unenforced
	logic bad_cfg, is1d, shape_ok, three;
	logic [CNT_W-1:0] ni1, nj1, nk1;

	always_comb begin
		bad_cfg = (ni_q == '0) || (nj_q == '0) || (nk_q == '0) ||
			(32'(ni_q) > MAX_DIM) || (32'(nj_q) > MAX_DIM) || (32'(nk_q) > MAX_DIM);
		is1d     = (nj_q == CNT_W'(1)) && (nk_q == CNT_W'(1));
		shape_ok = (nk_q == CNT_W'(1)) || ((ni_q > CNT_W'(1)) && (nj_q > CNT_W'(1)));
		three    = nk_q > CNT_W'(1);
		ni1 = (ni_q > CNT_W'(1)) ? ni_q - CNT_W'(1) : CNT_W'(1);
		nj1 = (nj_q > CNT_W'(1)) ? nj_q - CNT_W'(1) : CNT_W'(1);
		nk1 = (nk_q > CNT_W'(1)) ? nk_q - CNT_W'(1) : CNT_W'(1);
	end

	assign busy = 1'b0;

	// stage 1: plane products
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [P2_W-1:0]  pi_s1, pj_s1, pk_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= face_index;
		pi_s1  <= P2_W'(ni_q) * P2_W'(nj_q - CNT_W'(1));
		pj_s1  <= P2_W'(ni_q - CNT_W'(1)) * P2_W'(nj_q);
		pk_s1  <= P2_W'(ni_q - CNT_W'(1)) * P2_W'(nj_q - CNT_W'(1));
	end

	// stage 2: face counts per direction
	logic             v_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [P3_W-1:0]  fi_s2, fj_s2, fk_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		fi_s2  <= P3_W'(pi_s1) * P3_W'(nk1);
		fj_s2  <= P3_W'(pj_s1) * P3_W'(nk1);
		fk_s2  <= three ? P3_W'(pk_s1) * P3_W'(nk_q) : '0;
	end

	// stage 3: running face totals
	logic              v_s3;
	logic [IDX_W-1:0]  idx_s3;
	logic [P3_W-1:0]   fi_s3;
	logic [P3_W+1:0]   fij_s3, fall_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s3  <= idx_s2;
		fi_s3   <= fi_s2;
		fij_s3  <= (P3_W+2)'(fi_s2) + (P3_W+2)'(fj_s2);
		fall_s3 <= (P3_W+2)'(fi_s2) + (P3_W+2)'(fj_s2) + (P3_W+2)'(fk_s2);
	end

	// stage 4: direction select and local index
	logic             v_s4;
	logic [IDX_W-1:0] r_s4;
	logic [CNT_W-1:0] si_s4;
	status_t          st_s4;
	dir_t             dir_s4;

	logic [IDX_W-1:0] r_nxt;
	logic [CNT_W-1:0] si_nxt;
	status_t          st_nxt;
	dir_t             dir_nxt;
	logic [P3_W+1:0]  idx_w;

	always_comb begin
		idx_w   = (P3_W+2)'(idx_s3);
		r_nxt   = idx_s3;
		si_nxt  = CNT_W'(1);
		st_nxt  = ST_OK;
		dir_nxt = DIR_I;
		if (bad_cfg) begin
			st_nxt = ST_SHAPE;
		end else if (is1d) begin
			if ((ni_q > CNT_W'(1)) && (idx_w < (P3_W+2)'(ni_q - CNT_W'(1)))) begin
				si_nxt = ni_q;
			end else begin
				st_nxt = ST_RANGE;
			end
		end else if (shape_ok) begin
			if (idx_w < (P3_W+2)'(fi_s3)) begin
				si_nxt = ni_q;
			end else if (idx_w < fij_s3) begin
				dir_nxt = DIR_J;
				r_nxt   = idx_s3 - fi_s3[IDX_W-1:0];
				si_nxt  = ni_q - CNT_W'(1);
			end else if (idx_w < fall_s3) begin
				dir_nxt = DIR_K;
				r_nxt   = idx_s3 - fij_s3[IDX_W-1:0];
				si_nxt  = ni_q - CNT_W'(1);
			end else begin
				st_nxt = ST_RANGE;
			end
		end else begin
			st_nxt = ST_SHAPE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		r_s4   <= r_nxt;
		si_s4  <= si_nxt;
		st_s4  <= st_nxt;
		dir_s4 <= dir_nxt;
	end

	// first division: i = r % si, t = r / si
	logic             d1_v;
	logic [IDX_W-1:0] d1_q;
	logic [CNT_W-1:0] d1_r;
	logic [3:0]       d1_pay;

	sfid_div #(.DW(IDX_W), .VW(CNT_W), .PW(4), .BPS(4)) u_div_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.dividend  (r_s4),
		.divisor   (si_s4),
		.in_pay    ({st_s4, dir_s4}),
		.out_valid (d1_v),
		.quotient  (d1_q),
		.remainder (d1_r),
		.out_pay   (d1_pay)
	);

	// second division: j = t % sj, k = t / sj
	status_t          d1_st;
	dir_t             d1_dir;
	logic [CNT_W-1:0] sj;

	always_comb begin
		d1_st  = status_t'(d1_pay[3:2]);
		d1_dir = dir_t'(d1_pay[1:0]);
		if ((d1_st != ST_OK) || is1d) begin
			sj = CNT_W'(1);
		end else begin
			case (d1_dir)
				DIR_J:   sj = nj_q;
				default: sj = nj_q - CNT_W'(1);
			endcase
		end
	end

	logic                   d2_v;
	logic [IDX_W-1:0]       d2_q;
	logic [CNT_W-1:0]       d2_r;
	logic [CNT_W+3:0]       d2_pay;

	sfid_div #(.DW(IDX_W), .VW(CNT_W), .PW(CNT_W+4), .BPS(4)) u_div_j (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_v),
		.dividend  (d1_q),
		.divisor   (sj),
		.in_pay    ({d1_pay, d1_r}),
		.out_valid (d2_v),
		.quotient  (d2_q),
		.remainder (d2_r),
		.out_pay   (d2_pay)
	);

	// stage 5: first products and clamped cell coordinates
	logic             v_s5;
	status_t          st_s5;
	dir_t             dir_s5;
	logic [CNT_W-1:0] i_s5, ci_s5, k_s5, ck_s5;
	logic [P2_W-1:0]  jni_s5, cjn_s5, nij_s5, n11_s5;

	logic [CNT_W-1:0] i_w, k_w, ci_w, cj_w, ck_w;

	always_comb begin
		i_w  = d2_pay[CNT_W-1:0];
		k_w  = d2_q[CNT_W-1:0];
		ci_w = (i_w < ni1) ? i_w : ni1 - CNT_W'(1);
		cj_w = (d2_r < nj1) ? d2_r : nj1 - CNT_W'(1);
		ck_w = (k_w < nk1) ? k_w : nk1 - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		st_s5  <= status_t'(d2_pay[CNT_W+3:CNT_W+2]);
		dir_s5 <= dir_t'(d2_pay[CNT_W+1:CNT_W]);
		i_s5   <= i_w;
		ci_s5  <= ci_w;
		k_s5   <= k_w;
		ck_s5  <= ck_w;
		jni_s5 <= P2_W'(d2_r) * P2_W'(ni_q);
		cjn_s5 <= P2_W'(cj_w) * P2_W'(ni1);
		nij_s5 <= P2_W'(ni_q) * P2_W'(nj_q);
		n11_s5 <= P2_W'(ni1) * P2_W'(nj1);
	end

	// stage 6: plane offsets
	logic             v_s6;
	status_t          st_s6;
	dir_t             dir_s6;
	logic [CNT_W-1:0] i_s6, ci_s6;
	logic [P2_W-1:0]  jni_s6, cjn_s6, nij_s6;
	logic [IDX_W-1:0] knij_s6, ckn_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		st_s6   <= st_s5;
		dir_s6  <= dir_s5;
		i_s6    <= i_s5;
		ci_s6   <= ci_s5;
		jni_s6  <= jni_s5;
		cjn_s6  <= cjn_s5;
		nij_s6  <= nij_s5;
		knij_s6 <= IDX_W'(k_s5) * IDX_W'(nij_s5);
		ckn_s6  <= IDX_W'(ck_s5) * IDX_W'(n11_s5);
	end

	// stage 7: base node and cell
	logic             v_s7;
	status_t          st_s7;
	dir_t             dir_s7;
	logic [P2_W-1:0]  nij_s7;
	logic [IDX_W-1:0] a_s7, cell_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		st_s7   <= st_s6;
		dir_s7  <= dir_s6;
		nij_s7  <= nij_s6;
		a_s7    <= IDX_W'(i_s6) + IDX_W'(jni_s6) + knij_s6;
		cell_s7 <= IDX_W'(ci_s6) + IDX_W'(cjn_s6) + ckn_s6;
	end

	// output stage: corner steps and error zeroing
	logic [IDX_W-1:0] inc1, inc2;
	logic             done_q;
	logic [NODE_W-1:0] a_q, b_q, c_q, d_q, cell_q;
	logic [CORNER_W-1:0] cnt_q;
	logic [1:0]        dir_q, st_q;

	always_comb begin
		inc1 = IDX_W'(1);
		inc2 = IDX_W'(nij_s7);
		if (!is1d && (dir_s7 == DIR_I)) begin
			inc1 = IDX_W'(ni_q);
		end
		if (dir_s7 == DIR_K) begin
			inc2 = IDX_W'(ni_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		st_q <= st_s7;
		if (st_s7 != ST_OK) begin
			a_q    <= '0;
			b_q    <= '0;
			c_q    <= '0;
			d_q    <= '0;
			cnt_q  <= '0;
			cell_q <= '0;
			dir_q  <= DIR_I;
		end else begin
			a_q   <= a_s7[NODE_W-1:0];
			b_q   <= NODE_W'(a_s7 + inc1);
			dir_q <= dir_s7;
			cell_q <= is1d ? '0 : cell_s7[NODE_W-1:0];
			if (three) begin
				c_q   <= NODE_W'(a_s7 + inc1 + inc2);
				d_q   <= NODE_W'(a_s7 + inc2);
				cnt_q <= CORNERS_4;
			end else begin
				c_q   <= '0;
				d_q   <= '0;
				cnt_q <= CORNERS_2;
			end
		end
	end

	assign done         = done_q;
	assign node_a       = a_q;
	assign node_b       = b_q;
	assign node_c       = c_q;
	assign node_d       = d_q;
	assign corner_count = cnt_q;
	assign cell_index   = cell_q;
	assign face_dir     = dir_q;
	assign status       = st_q;

endmodule

// ===== rtl/sfid_div.sv =====
// sfid_div: pipelined restoring divider, BPS quotient bits per stage,
// with a side payload that travels alongside; no package dependencies
module sfid_div #(
	parameter int DW  = 32,
	parameter int VW  = 11,
	parameter int PW  = 4,
	parameter int BPS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder,
	output logic [PW-1:0] out_pay
);

	localparam int NSTG = DW / BPS;

	logic          vld_s [NSTG+1];
	logic [DW-1:0] q_s   [NSTG+1];
	logic [VW-1:0] rem_s [NSTG+1];
	logic [VW-1:0] dvs_s [NSTG+1];
	logic [PW-1:0] pay_s [NSTG+1];

	assign vld_s[0] = in_valid;
	assign q_s[0]   = dividend;
	assign rem_s[0] = '0;
	assign dvs_s[0] = divisor;
	assign pay_s[0] = in_pay;

	for (genvar st = 0; st < NSTG; st++) begin : g_stage
		logic [DW-1:0] q_nxt;
		logic [VW-1:0] rem_nxt;

		always_comb begin
			logic [VW:0]   sh;
			logic [VW-1:0] rr;
			logic [DW-1:0] qq;
			rr = rem_s[st];
			qq = q_s[st];
			for (int b = 0; b < BPS; b++) begin
				sh = {rr, qq[DW-1]};
				qq = {qq[DW-2:0], 1'b0};
				if (sh >= {1'b0, dvs_s[st]}) begin
					sh = sh - {1'b0, dvs_s[st]};
					qq[0] = 1'b1;
				end
				rr = sh[VW-1:0];
			end
			q_nxt   = qq;
			rem_nxt = rr;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[st+1] <= 1'b0;
			end else begin
				vld_s[st+1] <= vld_s[st];
			end
		end

		always_ff @(posedge clk) begin
			q_s[st+1]   <= q_nxt;
			rem_s[st+1] <= rem_nxt;
			dvs_s[st+1] <= dvs_s[st];
			pay_s[st+1] <= pay_s[st];
		end
	end

	assign out_valid = vld_s[NSTG];
	assign quotient  = q_s[NSTG];
	assign remainder = rem_s[NSTG];
	assign out_pay   = pay_s[NSTG];

endmodule

// ===== dv/tb_structured_face_index_decoder_top.sv =====
// tb_structured_face_index_decoder_top: self-checking bench for the face index decoder,
// predicts each decoded face from the node counts and compares it with the done strobe
// depends on sfid_pkg and structured_face_index_decoder_top
module tb_structured_face_index_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sfid_pkg::*;

	localparam int DIM_LIMIT = 1024;
	localparam int LATENCY = 24;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [NODE_W-1:0]   a;
		logic [NODE_W-1:0]   b;
		logic [NODE_W-1:0]   c;
		logic [NODE_W-1:0]   d;
		logic [CORNER_W-1:0] corners;
		logic [NODE_W-1:0]   own_cell;
		dir_t                dir;
		status_t             st;
	} face_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0] cfg_data;
	logic start;
	logic busy;
	logic [IDX_W-1:0] face_index;
	logic done;
	logic [NODE_W-1:0] node_a, node_b, node_c, node_d, cell_index;
	logic [CORNER_W-1:0] corner_count;
	logic [1:0] face_dir, status;

	logic [CNT_W-1:0] cnt_i, cnt_j, cnt_k;
	face_t pending_faces[$];
	int errors;
	int requests_sent;
	int faces_checked;
	int idle_cycles;
	bit allow_gaps;

	structured_face_index_decoder_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic face_t decode_face(logic [IDX_W-1:0] idx);
		face_t f;
		longint unsigned ni, nj, nk, ni1, nj1, nk1, fi, fj, fk, r, si, sj, inc1, inc2;
		longint unsigned i, j, k, t, a, cl;
		bit three;
		ni = cnt_i;
		nj = cnt_j;
		nk = cnt_k;
		f = '0;
		f.dir = DIR_I;
		f.st = ST_OK;
		if (ni == 0 || nj == 0 || nk == 0 || ni > DIM_LIMIT || nj > DIM_LIMIT ||
				nk > DIM_LIMIT) begin
			f.st = ST_SHAPE;
		end else if (nj == 1 && nk == 1) begin
			if (longint'(idx) + 1 < ni) begin
				f.a = NODE_W'(idx);
				f.b = NODE_W'(idx + 1);
				f.corners = CORNERS_2;
			end else begin
				f.st = ST_RANGE;
			end
		end else if (nk == 1 || (ni > 1 && nj > 1)) begin
			three = nk > 1;
			ni1 = ni > 2 ? ni - 1 : 1;
			nj1 = nj > 2 ? nj - 1 : 1;
			nk1 = nk > 2 ? nk - 1 : 1;
			fi = ni * (nj - 1) * nk1;
			fj = (ni - 1) * nj * nk1;
			fk = three ? (ni - 1) * (nj - 1) * nk : 0;
			r = idx;
			si = 1;
			sj = 1;
			inc1 = 0;
			inc2 = 0;
			if (r < fi) begin
				si = ni; sj = nj - 1; inc1 = ni; inc2 = ni * nj;
			end else if (r - fi < fj) begin
				r -= fi; f.dir = DIR_J;
				si = ni - 1; sj = nj; inc1 = 1; inc2 = ni * nj;
			end else if (r - fi - fj < fk) begin
				r -= fi + fj; f.dir = DIR_K;
				si = ni - 1; sj = nj - 1; inc1 = 1; inc2 = ni;
			end else begin
				f.st = ST_RANGE;
			end
			if (f.st == ST_OK) begin
				i = r % si; t = r / si;
				j = t % sj; k = t / sj;
				a = i + j * ni + k * ni * nj;
				f.a = NODE_W'(a);
				f.b = NODE_W'(a + inc1);
				if (three) begin
					f.c = NODE_W'(a + inc1 + inc2);
					f.d = NODE_W'(a + inc2);
					f.corners = CORNERS_4;
				end else begin
					f.corners = CORNERS_2;
				end
				cl = (i < ni1 ? i : ni1 - 1) + (j < nj1 ? j : nj1 - 1) * ni1 +
					(k < nk1 ? k : nk1 - 1) * ni1 * nj1;
				f.own_cell = NODE_W'(cl);
			end else begin
				f.dir = DIR_I;
			end
		end else begin
			f.st = ST_SHAPE;
		end
		return f;
	endfunction

	function automatic longint unsigned face_total();
		longint unsigned ni, nj, nk, nk1;
		ni = cnt_i; nj = cnt_j; nk = cnt_k;
		nk1 = nk > 2 ? nk - 1 : 1;
		if (nj == 1 && nk == 1) return ni > 1 ? ni - 1 : 0;
		return ni * (nj - 1) * nk1 + (ni - 1) * nj * nk1 +
			(nk > 1 ? (ni - 1) * (nj - 1) * nk : 0);
	endfunction

	task automatic idle_burst();
		repeat ($urandom_range(1, 7)) @(posedge clk);
	endtask

	task automatic send_face(logic [IDX_W-1:0] idx);
		if (allow_gaps && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			idle_burst();
		end
		start <= 1'b1;
		face_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_faces.push_back(decode_face(idx));
		requests_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_faces.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NODES_I) cnt_i = val;
		else if (idx == REG_NODES_J) cnt_j = val;
		else cnt_k = val;
	endtask

	task automatic set_grid(logic [CNT_W-1:0] ni, logic [CNT_W-1:0] nj, logic [CNT_W-1:0] nk);
		drain();
		write_reg(REG_NODES_I, ni);
		write_reg(REG_NODES_J, nj);
		write_reg(REG_NODES_K, nk);
	endtask

	function automatic logic [IDX_W-1:0] random_face();
		longint unsigned total;
		total = face_total();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return total > 0 ? IDX_W'(total - 1) : 32'd0;
			2: return IDX_W'(total);
			default: return total > 0 ? IDX_W'($urandom() % total) : $urandom_range(0, 3);
		endcase
	endfunction

	task automatic test_directed();
		send_face(32'd0);
		send_face(32'hFFFF_FFFF);
		set_grid(11'd1024, 11'd1, 11'd1);
		send_face(32'd0);
		send_face(32'd1022);
		send_face(32'd1023);
		send_face(32'hC000_0000);
		set_grid(11'd4, 11'd3, 11'd1);
		for (int n = 0; n < 19; n++) send_face(n);
		set_grid(11'd1, 11'd5, 11'd1);
		for (int n = 0; n < 6; n++) send_face(n);
	endtask

	task automatic test_bad_shapes();
		set_grid(11'd0, 11'd3, 11'd3);
		send_face($urandom());
		set_grid(11'd1025, 11'd2, 11'd2);
		send_face(32'd0);
		set_grid(11'd2047, 11'd2047, 11'd2047);
		send_face(32'd5);
		set_grid(11'd1, 11'd4, 11'd4);
		send_face(32'd0);
		set_grid(11'd3, 11'd1, 11'd4);
		send_face(32'd1);
	endtask

	task automatic test_3d_extremes();
		set_grid(11'd1024, 11'd1024, 11'd1024);
		send_face(32'd0);
		send_face(32'hBFD0_0BFF);
		send_face(32'hBFD0_0C00);
		send_face(32'hBFFF_FFFF);
		send_face(32'hC000_0000);
		set_grid(11'd2, 11'd2, 11'd2);
		for (int n = 0; n < 13; n++) send_face(n);
	endtask

	task automatic test_random(int num_items, bit gaps);
		int left;
		logic [CNT_W-1:0] ni, nj, nk;
		left = num_items;
		allow_gaps = gaps;
		while (left > 0) begin
			ni = $urandom_range(0, 5) == 0 ? CNT_W'($urandom_range(1000, 1024)) :
				CNT_W'($urandom_range(1, 12));
			nj = $urandom_range(0, 3) == 0 ? 11'd1 : 11'($urandom_range(2, 12));
			nk = $urandom_range(0, 2) == 0 ? 11'd1 : 11'($urandom_range(2, 1024));
			if ($urandom_range(0, 15) == 0) nk = CNT_W'($urandom());
			set_grid(ni, nj, nk);
			for (int n = 0; n < 50 && left > 0; n++) begin
				send_face(random_face());
				left--;
			end
		end
		allow_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		face_t got, want;
		if (arst_n && done) begin
			got = {node_a, node_b, node_c, node_d, corner_count, cell_index,
				dir_t'(face_dir), status_t'(status)};
			if (pending_faces.size() == 0) begin
				$display("%0t: result with no request pending, actual %h", $time, got);
				errors++;
			end else begin
				want = pending_faces.pop_front();
				faces_checked++;
				if (got.a !== want.a) begin
					$display("%0t: node_a expected %0d actual %0d", $time, want.a, got.a);
					errors++;
				end
				if (got.b !== want.b) begin
					$display("%0t: node_b expected %0d actual %0d", $time, want.b, got.b);
					errors++;
				end
				if (got.c !== want.c) begin
					$display("%0t: node_c expected %0d actual %0d", $time, want.c, got.c);
					errors++;
				end
				if (got.d !== want.d) begin
					$display("%0t: node_d expected %0d actual %0d", $time, want.d, got.d);
					errors++;
				end
				if (got.corners !== want.corners) begin
					$display("%0t: corner_count expected %0d actual %0d", $time,
						want.corners, got.corners);
					errors++;
				end
				if (got.own_cell !== want.own_cell) begin
					$display("%0t: cell_index expected %0d actual %0d", $time,
						want.own_cell, got.own_cell);
					errors++;
				end
				if (got.dir !== want.dir) begin
					$display("%0t: face_dir expected %0d actual %0d", $time, want.dir, got.dir);
					errors++;
				end
				if (got.st !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		errors = 0;
		requests_sent = 0;
		faces_checked = 0;
		idle_cycles = 0;
		allow_gaps = 1'b0;
		cnt_i = 11'd1;
		cnt_j = 11'd1;
		cnt_k = 11'd1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NODES_I;
		cfg_data = '0;
		start = 1'b0;
		face_index = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_bad_shapes();
		test_3d_extremes();
		test_random(800, 1'b1);
		test_random(200, 1'b0);
		drain();
		$display("covered %0d requests, %0d results checked over 1D, 2D, 3D and bad grids",
			requests_sent, faces_checked);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== structured_face_index_decoder_top.f =====
rtl/sfid_pkg.sv
rtl/sfid_div.sv
rtl/structured_face_index_decoder_top.sv
dv/tb_structured_face_index_decoder_top.sv
